@@ sv/ccircle_pkg.sv @@
`timescale 1ns / 1ps
package ccircle_pkg;

	localparam int COORD_BITS_DEF = 9;
	localparam int CENTER_W       = 30;
	localparam int RADIUS_W       = 34;
	localparam int QUEUE_DEPTH    = 4;

	// offset magnitude kept for the radius; larger offsets saturate the radius
	localparam int MAG_W  = 31;
	localparam int SQ_W   = 2 * MAG_W + 1;
	// squared distance times 256, padded to an even width for the root
	localparam int RAD_W  = SQ_W + 9;
	localparam int ROOT_W = RAD_W / 2;

	localparam logic signed [63:0] CENTER_MAX   = 64'sd536870911;
	localparam logic signed [63:0] CENTER_MIN   = -64'sd536870912;
	localparam logic [63:0]        OFFSET_LIMIT = 64'd2147483647;
	localparam logic [RADIUS_W-1:0] RADIUS_MAX  = '1;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ sv/ccircle_if.sv @@
`timescale 1ns / 1ps
interface ccircle_pts_if #(
	parameter int COORD_BITS = ccircle_pkg::COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] ax;
	logic [COORD_BITS-1:0] ay;
	logic [COORD_BITS-1:0] bx;
	logic [COORD_BITS-1:0] by_coord;
	logic [COORD_BITS-1:0] cx;
	logic [COORD_BITS-1:0] cy;

	modport source(output valid, ax, ay, bx, by_coord, cx, cy, input ready);
	modport sink(input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface ccircle_circ_if;
	logic                                valid;
	logic                                ready;
	logic                                collinear;
	logic signed [ccircle_pkg::CENTER_W-1:0] center_x;
	logic signed [ccircle_pkg::CENTER_W-1:0] center_y;
	logic [ccircle_pkg::RADIUS_W-1:0]    radius_q4;

	modport source(output valid, collinear, center_x, center_y, radius_q4, input ready);
	modport sink(input valid, collinear, center_x, center_y, radius_q4, output ready);
endinterface

@@ sv/ccircle_front.sv @@
`timescale 1ns / 1ps
module ccircle_front #(
	parameter int COORD_BITS = ccircle_pkg::COORD_BITS_DEF,
	localparam int N    = COORD_BITS,
	localparam int DW   = 2 * N + 3,
	localparam int NW   = 3 * N + 4,
	localparam int EntW = 1 + 2 * NW + DW + 2 * N
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ccircle_pts_if.sink          pts,
	input  ccircle_pkg::q_stat_t qstat,
	output logic                 push,
	output logic [EntW-1:0]      ent
);
	localparam int BW  = 2 * N + 2;
	localparam int SQW = 2 * N + 1;
	localparam int PW  = 3 * N + 3;

	logic en;

	// stage 1: differences, squares, determinant
	logic signed [N:0]      dxab, dyac, dyab, dxac, dyba, dxca;
	logic [2*N-1:0]         ax2, ay2, bx2, by2, cx2, cy2;
	logic [SQW-1:0]         sq1, sq2, sq3;
	logic signed [2*N+1:0]  p1, p2;
	logic signed [DW-1:0]   det_c;
	logic signed [BW-1:0]   b1_c, b2_c;

	always_comb begin
		dxab = signed'({1'b0, pts.ax}) - signed'({1'b0, pts.bx});
		dyac = signed'({1'b0, pts.ay}) - signed'({1'b0, pts.cy});
		dyab = signed'({1'b0, pts.ay}) - signed'({1'b0, pts.by_coord});
		dxac = signed'({1'b0, pts.ax}) - signed'({1'b0, pts.cx});
		dyba = signed'({1'b0, pts.by_coord}) - signed'({1'b0, pts.ay});
		dxca = signed'({1'b0, pts.cx}) - signed'({1'b0, pts.ax});
		ax2  = pts.ax * pts.ax;
		ay2  = pts.ay * pts.ay;
		bx2  = pts.bx * pts.bx;
		by2  = pts.by_coord * pts.by_coord;
		cx2  = pts.cx * pts.cx;
		cy2  = pts.cy * pts.cy;
		sq1  = SQW'(ax2) + SQW'(ay2);
		sq2  = SQW'(bx2) + SQW'(by2);
		sq3  = SQW'(cx2) + SQW'(cy2);
		p1   = dxab * dyac;
		p2   = dyab * dxac;
		det_c = DW'(p1) - DW'(p2);
		b1_c = signed'({1'b0, sq1}) - signed'({1'b0, sq2});
		b2_c = signed'({1'b0, sq1}) - signed'({1'b0, sq3});
	end

	logic                 v_s1;
	logic signed [DW-1:0] det_s1;
	logic signed [BW-1:0] b1_s1, b2_s1;
	logic signed [N:0]    dyac_s1, dyba_s1, dxca_s1, dxab_s1;
	logic [N-1:0]         ax_s1, ay_s1;

	// stage 2: numerators, halved toward zero
	logic signed [PW-1:0] m1, m2, m3, m4;
	logic signed [NW-1:0] nx, ny, nxr, nyr, hx_c, hy_c;

	always_comb begin
		m1   = dyac_s1 * b1_s1;
		m2   = dyba_s1 * b2_s1;
		m3   = dxca_s1 * b1_s1;
		m4   = dxab_s1 * b2_s1;
		nx   = NW'(m1) + NW'(m2);
		ny   = NW'(m3) + NW'(m4);
		nxr  = nx + signed'({{(NW-1){1'b0}}, nx[NW-1]});
		nyr  = ny + signed'({{(NW-1){1'b0}}, ny[NW-1]});
		hx_c = nxr >>> 1;
		hy_c = nyr >>> 1;
	end

	logic                 v_s2;
	logic                 col_s2;
	logic signed [NW-1:0] hx_s2, hy_s2;
	logic signed [DW-1:0] det_s2;
	logic [N-1:0]         ax_s2, ay_s2;

	assign en        = !(v_s2 && qstat.full);
	assign pts.ready = en;
	assign push      = v_s2 && !qstat.full;
	assign ent       = {col_s2, hx_s2, hy_s2, det_s2, ax_s2, ay_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= pts.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s1  <= det_c;
			b1_s1   <= b1_c;
			b2_s1   <= b2_c;
			dyac_s1 <= dyac;
			dyba_s1 <= dyba;
			dxca_s1 <= dxca;
			dxab_s1 <= dxab;
			ax_s1   <= pts.ax;
			ay_s1   <= pts.ay;
			col_s2  <= (det_s1 == '0);
			hx_s2   <= hx_c;
			hy_s2   <= hy_c;
			det_s2  <= det_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
		end
	end

endmodule

@@ sv/ccircle_queue.sv @@
`timescale 1ns / 1ps
module ccircle_queue #(
	parameter int DataW = 8,
	parameter int Depth = ccircle_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DataW-1:0]     wdata,
	input  logic                 pop,
	output logic [DataW-1:0]     rdata,
	output ccircle_pkg::q_stat_t stat
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [DataW-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_q, rd_q;
	logic [CntW-1:0]  count_q;

	assign stat.full  = (count_q == CntW'(Depth));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a write");

endmodule

@@ sv/ccircle_div.sv @@
`timescale 1ns / 1ps
module ccircle_div #(
	parameter int NumW = 30,
	parameter int DenW = 21,
	parameter int TagW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_i,
	input  logic [NumW-1:0] num_x,
	input  logic [NumW-1:0] num_y,
	input  logic [DenW-1:0] den,
	input  logic [TagW-1:0] tag_i,
	output logic            v_o,
	output logic [NumW-1:0] quo_x,
	output logic [NumW-1:0] quo_y,
	output logic [TagW-1:0] tag_o
);
	// one quotient bit per stage for both lanes
	logic [NumW-1:0] qx_s  [NumW+1];
	logic [NumW-1:0] qy_s  [NumW+1];
	logic [DenW-1:0] rx_s  [NumW+1];
	logic [DenW-1:0] ry_s  [NumW+1];
	logic [DenW-1:0] den_s [NumW+1];
	logic [TagW-1:0] tag_s [NumW+1];
	logic            v_s   [NumW+1];

	always_comb begin
		qx_s[0]  = num_x;
		qy_s[0]  = num_y;
		rx_s[0]  = '0;
		ry_s[0]  = '0;
		den_s[0] = den;
		tag_s[0] = tag_i;
		v_s[0]   = v_i;
	end

	for (genvar s = 0; s < NumW; s++) begin : g_stage
		logic [DenW:0] tx, ty;
		logic          gx, gy;

		always_comb begin
			tx = {rx_s[s], qx_s[s][NumW-1]};
			ty = {ry_s[s], qy_s[s][NumW-1]};
			gx = (tx >= {1'b0, den_s[s]});
			gy = (ty >= {1'b0, den_s[s]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[s+1] <= 1'b0;
			else if (en)
				v_s[s+1] <= v_s[s];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[s+1]  <= gx ? DenW'(tx - {1'b0, den_s[s]}) : DenW'(tx);
				ry_s[s+1]  <= gy ? DenW'(ty - {1'b0, den_s[s]}) : DenW'(ty);
				qx_s[s+1]  <= {qx_s[s][NumW-2:0], gx};
				qy_s[s+1]  <= {qy_s[s][NumW-2:0], gy};
				den_s[s+1] <= den_s[s];
				tag_s[s+1] <= tag_s[s];
			end
		end
	end

	assign v_o   = v_s[NumW];
	assign quo_x = qx_s[NumW];
	assign quo_y = qy_s[NumW];
	assign tag_o = tag_s[NumW];

endmodule

@@ sv/ccircle_sqrt.sv @@
`timescale 1ns / 1ps
module ccircle_sqrt #(
	parameter int TagW = 8,
	localparam int RadW = ccircle_pkg::RAD_W,
	localparam int RtW  = ccircle_pkg::ROOT_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_i,
	input  logic [RadW-1:0] rad,
	input  logic [TagW-1:0] tag_i,
	output logic            v_o,
	output logic [RtW-1:0]  root,
	output logic [TagW-1:0] tag_o
);
	// one root bit per stage, two radicand bits consumed each
	logic [RadW-1:0] rad_s  [RtW+1];
	logic [RtW+1:0]  rem_s  [RtW+1];
	logic [RtW-1:0]  root_s [RtW+1];
	logic [TagW-1:0] tag_s  [RtW+1];
	logic            v_s    [RtW+1];

	always_comb begin
		rad_s[0]  = rad;
		rem_s[0]  = '0;
		root_s[0] = '0;
		tag_s[0]  = tag_i;
		v_s[0]    = v_i;
	end

	for (genvar s = 0; s < RtW; s++) begin : g_stage
		logic [RtW+1:0] t, trial;
		logic           g;

		always_comb begin
			t     = {rem_s[s][RtW-1:0], rad_s[s][RadW-1 -: 2]};
			trial = {root_s[s], 2'b01};
			g     = (t >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[s+1] <= 1'b0;
			else if (en)
				v_s[s+1] <= v_s[s];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s+1]  <= g ? t - trial : t;
				root_s[s+1] <= {root_s[s][RtW-2:0], g};
				rad_s[s+1]  <= {rad_s[s][RadW-3:0], 2'b00};
				tag_s[s+1]  <= tag_s[s];
			end
		end
	end

	assign v_o   = v_s[RtW];
	assign root  = root_s[RtW];
	assign tag_o = tag_s[RtW];

endmodule

@@ sv/ccircle_back.sv @@
`timescale 1ns / 1ps
module ccircle_back #(
	parameter int COORD_BITS = ccircle_pkg::COORD_BITS_DEF,
	localparam int N    = COORD_BITS,
	localparam int DW   = 2 * N + 3,
	localparam int NW   = 3 * N + 4,
	localparam int EntW = 1 + 2 * NW + DW + 2 * N
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [EntW-1:0]      ent,
	input  ccircle_pkg::q_stat_t qstat,
	output logic                 pop,
	ccircle_circ_if.source       circ
);
	localparam int QW    = NW - 1;
	localparam int OffW  = QW + 2;
	localparam int CW    = ccircle_pkg::CENTER_W;
	localparam int RW    = ccircle_pkg::RADIUS_W;
	localparam int MW    = ccircle_pkg::MAG_W;
	localparam int SW    = ccircle_pkg::SQ_W;
	localparam int RadW  = ccircle_pkg::RAD_W;
	localparam int RtW   = ccircle_pkg::ROOT_W;
	localparam int TagD  = 3 + 2 * N;
	localparam int TagS  = 2 + 2 * CW;
	localparam int OffAx = N;
	localparam int OffDt = 2 * N;
	localparam int OffHy = 2 * N + DW;
	localparam int OffHx = 2 * N + DW + NW;

	logic en;
	logic v_q;

	assign en  = !v_q || circ.ready;
	assign pop = !qstat.empty && en;

	// unpack queue word
	logic                 e_col;
	logic signed [NW-1:0] e_hx, e_hy, e_hxa, e_hya;
	logic signed [DW-1:0] e_det, e_dta;
	logic [N-1:0]         e_ax, e_ay;

	always_comb begin
		e_col = ent[EntW-1];
		e_hx  = ent[OffHx +: NW];
		e_hy  = ent[OffHy +: NW];
		e_det = ent[OffDt +: DW];
		e_ax  = ent[OffAx +: N];
		e_ay  = ent[0 +: N];
		e_hxa = e_hx[NW-1] ? -e_hx : e_hx;
		e_hya = e_hy[NW-1] ? -e_hy : e_hy;
		e_dta = e_det[DW-1] ? -e_det : e_det;
	end

	// b0: magnitudes into the divider
	logic            v_b0;
	logic [QW-1:0]   nx_b0, ny_b0;
	logic [DW-1:0]   den_b0;
	logic [TagD-1:0] tag_b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_b0 <= 1'b0;
		else if (en)
			v_b0 <= pop;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_b0  <= QW'(e_hxa);
			ny_b0  <= QW'(e_hya);
			den_b0 <= e_dta;
			tag_b0 <= {e_col, e_hx[NW-1] ^ e_det[DW-1], e_hy[NW-1] ^ e_det[DW-1],
				e_ax, e_ay};
		end
	end

	logic            v_dv;
	logic [QW-1:0]   qx, qy;
	logic [TagD-1:0] tag_dv;

	ccircle_div #(
		.NumW(QW),
		.DenW(DW),
		.TagW(TagD)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.v_i   (v_b0),
		.num_x (nx_b0),
		.num_y (ny_b0),
		.den   (den_b0),
		.tag_i (tag_b0),
		.v_o   (v_dv),
		.quo_x (qx),
		.quo_y (qy),
		.tag_o (tag_dv)
	);

	// c1: signed centers, clamp, offsets from the first point
	logic                 d_col, d_sx, d_sy;
	logic [N-1:0]         d_ax, d_ay;
	logic signed [QW:0]   px, py;
	logic signed [63:0]   pxe, pye;
	logic signed [CW-1:0] cx_c, cy_c;
	logic signed [OffW-1:0] dx_c, dy_c;

	always_comb begin
		{d_col, d_sx, d_sy, d_ax, d_ay} = tag_dv;
		px   = d_sx ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
		py   = d_sy ? -signed'({1'b0, qy}) : signed'({1'b0, qy});
		pxe  = 64'(px);
		pye  = 64'(py);
		cx_c = (pxe > ccircle_pkg::CENTER_MAX) ? CW'(ccircle_pkg::CENTER_MAX) :
			(pxe < ccircle_pkg::CENTER_MIN) ? CW'(ccircle_pkg::CENTER_MIN) : CW'(pxe);
		cy_c = (pye > ccircle_pkg::CENTER_MAX) ? CW'(ccircle_pkg::CENTER_MAX) :
			(pye < ccircle_pkg::CENTER_MIN) ? CW'(ccircle_pkg::CENTER_MIN) : CW'(pye);
		dx_c = OffW'(signed'({1'b0, d_ax})) - OffW'(px);
		dy_c = OffW'(signed'({1'b0, d_ay})) - OffW'(py);
	end

	logic                   v_c1, col_c1;
	logic signed [CW-1:0]   cx_c1, cy_c1;
	logic signed [OffW-1:0] dx_c1, dy_c1;

	// c2: offset magnitudes squared
	logic [OffW-1:0] adx, ady;
	logic            over_c;
	logic [MW-1:0]   mx, my;
	logic [SW-2:0]   sqx_c, sqy_c;

	always_comb begin
		adx    = dx_c1[OffW-1] ? OffW'(-dx_c1) : OffW'(dx_c1);
		ady    = dy_c1[OffW-1] ? OffW'(-dy_c1) : OffW'(dy_c1);
		over_c = (64'(adx) > ccircle_pkg::OFFSET_LIMIT) ||
			(64'(ady) > ccircle_pkg::OFFSET_LIMIT);
		mx     = MW'(adx);
		my     = MW'(ady);
		sqx_c  = mx * mx;
		sqy_c  = my * my;
	end

	logic                 v_c2, col_c2, over_c2;
	logic signed [CW-1:0] cx_c2, cy_c2;
	logic [SW-2:0]        sqx_c2, sqy_c2;

	// c3: squared distance, scaled by 256 for four fraction bits
	logic            v_c3;
	logic [RadW-1:0] rad_c3;
	logic [TagS-1:0] tag_c3;
	logic [SW-1:0]   d2;

	assign d2 = SW'(sqx_c2) + SW'(sqy_c2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1 <= 1'b0;
			v_c2 <= 1'b0;
			v_c3 <= 1'b0;
		end else if (en) begin
			v_c1 <= v_dv;
			v_c2 <= v_c1;
			v_c3 <= v_c2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_c1  <= d_col;
			cx_c1   <= cx_c;
			cy_c1   <= cy_c;
			dx_c1   <= dx_c;
			dy_c1   <= dy_c;
			col_c2  <= col_c1;
			over_c2 <= over_c;
			cx_c2   <= cx_c1;
			cy_c2   <= cy_c1;
			sqx_c2  <= sqx_c;
			sqy_c2  <= sqy_c;
			rad_c3  <= RadW'({d2, 8'b0});
			tag_c3  <= {col_c2, over_c2, cx_c2, cy_c2};
		end
	end

	logic            v_rt;
	logic [RtW-1:0]  root;
	logic [TagS-1:0] tag_rt;

	ccircle_sqrt #(
		.TagW(TagS)
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.v_i   (v_c3),
		.rad   (rad_c3),
		.tag_i (tag_c3),
		.v_o   (v_rt),
		.root  (root),
		.tag_o (tag_rt)
	);

	// output register
	logic                 r_col, r_over;
	logic signed [CW-1:0] r_cx, r_cy;
	logic [RW-1:0]        rad_c;
	logic                 col_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic [RW-1:0]        rq_q;

	always_comb begin
		{r_col, r_over, r_cx, r_cy} = tag_rt;
		if (r_over || root > RtW'(ccircle_pkg::RADIUS_MAX))
			rad_c = ccircle_pkg::RADIUS_MAX;
		else
			rad_c = RW'(root);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= v_rt;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_q <= r_col;
			cx_q  <= r_col ? '0 : r_cx;
			cy_q  <= r_col ? '0 : r_cy;
			rq_q  <= r_col ? '0 : rad_c;
		end
	end

	assign circ.valid     = v_q;
	assign circ.collinear = col_q;
	assign circ.center_x  = cx_q;
	assign circ.center_y  = cy_q;
	assign circ.radius_q4 = rq_q;

	a_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(circ.valid && circ.collinear) |->
			(circ.center_x == '0 && circ.center_y == '0 && circ.radius_q4 == '0))
		else $error("collinear word carries a circle");

	a_over_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_rt && !r_col && r_over) |=> circ.radius_q4 == ccircle_pkg::RADIUS_MAX)
		else $error("far center did not saturate radius");

endmodule

@@ sv/circumcircle_from_three_points_core.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Word
// pts      in   ax, ay, bx, by_coord, cx, cy (COORD_BITS each, unsigned)
// circ     out  collinear, center_x, center_y (30b signed), radius_q4 (34b)
//
// Takes one word per cycle and returns one word per cycle in steady state,
// while circ is ready. A word passes two front stages, the queue, a divider
// of one quotient bit per stage and a square root of one bit per stage.
// arst_n clears all valid bits and the queue; no clearing pass is needed.
// A stall on circ freezes the back pipeline; the four-word queue lets the
// front keep taking words until it fills, then pts.ready drops.
module circumcircle_from_three_points_core #(
	parameter int COORD_BITS = ccircle_pkg::COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ccircle_pts_if.sink  pts,
	ccircle_circ_if.source circ
);
	localparam int N    = COORD_BITS;
	localparam int DW   = 2 * N + 3;
	localparam int NW   = 3 * N + 4;
	localparam int EntW = 1 + 2 * NW + DW + 2 * N;

	logic                 push, pop;
	logic [EntW-1:0]      wr_ent, rd_ent;
	ccircle_pkg::q_stat_t qstat;

	ccircle_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.pts   (pts),
		.qstat (qstat),
		.push  (push),
		.ent   (wr_ent)
	);

	ccircle_queue #(
		.DataW(EntW),
		.Depth(ccircle_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wr_ent),
		.pop   (pop),
		.rdata (rd_ent),
		.stat  (qstat)
	);

	ccircle_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.ent   (rd_ent),
		.qstat (qstat),
		.pop   (pop),
		.circ  (circ)
	);

endmodule
